FILE: hw/rtl/rrt_pkg.sv
// Package of the RRT extend step: widths, codes, sequencer states and shared types.
// Used by rrt_sqdist, rrt_rootdiv, the top level and the checker; it depends on nothing.
`default_nettype none

package rrt_pkg;

  // Field and datapath widths fixed by the Q8.8 number format.
  localparam int COORD_W  = 16;
  localparam int LEN_W    = 15;
  localparam int DIFF_W   = 17;
  localparam int SQ_W     = 32;
  localparam int DIST_W   = 33;
  localparam int LIMSQ_W  = 30;
  localparam int ROOT_W   = 17;
  localparam int NUM_W    = 32;
  localparam int SQ_ITER  = 17;
  localparam int DIV_ITER = 32;
  localparam int ITER_W   = 6;
  localparam int OCNT_W   = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OBS_COUNT = 3'd5;

  // Register reset values.
  localparam logic signed [COORD_W-1:0] GOAL_X_RST   = 16'sd1536;
  localparam logic signed [COORD_W-1:0] GOAL_Y_RST   = 16'sd1792;
  localparam logic [LEN_W-1:0]          STEP_LEN_RST = 15'd256;

  // Operation codes.
  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_EXTEND  = 2'd2;

  // Result status codes.
  localparam logic [2:0] STATUS_ACK    = 3'd0;
  localparam logic [2:0] STATUS_ADDED  = 3'd1;
  localparam logic [2:0] STATUS_REJECT = 3'd2;
  localparam logic [2:0] STATUS_GOAL   = 3'd3;
  localparam logic [2:0] STATUS_NONE   = 3'd4;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROOT,
    ST_ROOT_W,
    ST_MULX,
    ST_DIVX,
    ST_DIVX_W,
    ST_MULY,
    ST_DIVY,
    ST_DIVY_W,
    ST_SAT,
    ST_OBST,
    ST_COMMIT,
    ST_RESP
  } seq_state_e;

  // Operation of the iterative root and divide unit.
  typedef enum logic {
    RD_SQRT,
    RD_DIV
  } rd_mode_e;

  // Result of the squared distance unit.
  typedef struct packed {
    logic                     valid;
    logic                     le;
    logic [DIST_W-1:0]        dsq;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } sqd_res_t;

  // Clamp an 18 bit signed sum to the 16 bit signed coordinate range.
  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [COORD_W+1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rrt_in_if.sv
// Input channel of the RRT extend step: valid, ready and one command item.
// Depends on nothing but the field widths written here.
`default_nettype none

interface rrt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic               use_goal;
  logic [2:0]         obstacle_slot;
  logic signed [15:0] obstacle_x;
  logic signed [15:0] obstacle_y;
  logic [14:0]        obstacle_radius;

  modport source (
    output valid, operation, sample_x, sample_y, use_goal,
    output obstacle_slot, obstacle_x, obstacle_y, obstacle_radius,
    input  ready
  );
  modport sink (
    input  valid, operation, sample_x, sample_y, use_goal,
    input  obstacle_slot, obstacle_x, obstacle_y, obstacle_radius,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/rrt_out_if.sv
// Result channel of the RRT extend step: valid, ready and one result item.
// IDX_W follows the node count of the tree that drives it.
`default_nettype none

interface rrt_out_if #(
  parameter int IDX_W = 9
);
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [IDX_W-1:0]   node_index;
  logic signed [15:0] node_x;
  logic signed [15:0] node_y;
  logic [IDX_W-1:0]   parent_index;

  modport source (
    output valid, status, node_index, node_x, node_y, parent_index,
    input  ready
  );
  modport sink (
    input  valid, status, node_index, node_x, node_y, parent_index,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/rrt_ram.sv
// Generic single write port RAM with one registered read port.
// Stands alone; used for the node table and the obstacle table.
`default_nettype none

module rrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rrt_sqdist.sv
// Two stage squared distance unit shared by the node scan, obstacle and goal tests.
// Depends on rrt_pkg for widths and the result struct.
`default_nettype none

module rrt_sqdist (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire logic signed [rrt_pkg::COORD_W-1:0] ax_i,
  input  wire logic signed [rrt_pkg::COORD_W-1:0] ay_i,
  input  wire logic signed [rrt_pkg::COORD_W-1:0] bx_i,
  input  wire logic signed [rrt_pkg::COORD_W-1:0] by_i,
  input  wire logic        [rrt_pkg::LEN_W-1:0]   lim_i,
  output rrt_pkg::sqd_res_t                       res_o
);

  logic                                  v1_q, v2_q;
  logic signed [rrt_pkg::DIFF_W-1:0]     dx1_q, dy1_q, dx2_q, dy2_q;
  logic        [rrt_pkg::LEN_W-1:0]      lim1_q;
  logic        [rrt_pkg::SQ_W-1:0]       sqx_q, sqy_q;
  logic        [rrt_pkg::LIMSQ_W-1:0]    limsq_q;
  logic signed [2*rrt_pkg::DIFF_W-1:0]   px, py;
  logic        [2*rrt_pkg::LEN_W-1:0]    pl;
  logic        [rrt_pkg::DIST_W-1:0]     dsum;

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // The squares are non-negative and below 2^32.
  assign px = dx1_q * dx1_q;
  assign py = dy1_q * dy1_q;
  assign pl = lim1_q * lim1_q;

  // Differences in the first stage, squares in the second.
  always_ff @(posedge clk_i) begin
    dx1_q   <= {ax_i[rrt_pkg::COORD_W-1], ax_i} - {bx_i[rrt_pkg::COORD_W-1], bx_i};
    dy1_q   <= {ay_i[rrt_pkg::COORD_W-1], ay_i} - {by_i[rrt_pkg::COORD_W-1], by_i};
    lim1_q  <= lim_i;
    sqx_q   <= px[rrt_pkg::SQ_W-1:0];
    sqy_q   <= py[rrt_pkg::SQ_W-1:0];
    limsq_q <= pl;
    dx2_q   <= dx1_q;
    dy2_q   <= dy1_q;
  end

  assign dsum = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    res_o.valid = v2_q;
    res_o.dsq   = dsum;
    res_o.le    = dsum <= rrt_pkg::DIST_W'(limsq_q);
    res_o.dx    = dx2_q;
    res_o.dy    = dy2_q;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rrt_rootdiv.sv
// Iterative unit: integer square root, one result bit a cycle, or restoring divide.
// Depends on rrt_pkg for widths, iteration counts and the mode type.
`default_nettype none

module rrt_rootdiv (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire rrt_pkg::rd_mode_e                mode_i,
  input  wire logic [rrt_pkg::DIST_W-1:0]       rad_i,
  input  wire logic [rrt_pkg::NUM_W-1:0]        num_i,
  input  wire logic [rrt_pkg::ROOT_W-1:0]       den_i,
  output logic                                  done_o,
  output logic      [rrt_pkg::NUM_W-1:0]        res_o
);

  localparam int RW = rrt_pkg::DIST_W + 1;
  localparam logic [RW-1:0] BIT0 = RW'(1) << (rrt_pkg::DIST_W - 1);

  logic                          busy_q, done_q, last;
  rrt_pkg::rd_mode_e             mode_q;
  logic [rrt_pkg::ITER_W-1:0]    cnt_q;
  logic [RW-1:0]                 rem_q, root_q, bit_q, trial;
  logic [rrt_pkg::ROOT_W-1:0]    drem_q, den_q;
  logic [rrt_pkg::NUM_W-1:0]     quo_q;
  logic [rrt_pkg::ROOT_W:0]      sh;

  assign trial = root_q + bit_q;
  assign sh    = {drem_q, quo_q[rrt_pkg::NUM_W-1]};
  assign last  = (mode_q == rrt_pkg::RD_SQRT) ?
                 (cnt_q == rrt_pkg::ITER_W'(rrt_pkg::SQ_ITER - 1)) :
                 (cnt_q == rrt_pkg::ITER_W'(rrt_pkg::DIV_ITER - 1));

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= rrt_pkg::RD_SQRT;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        mode_q <= mode_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // One root bit or one quotient bit each busy cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, rad_i};
      root_q <= '0;
      bit_q  <= BIT0;
      drem_q <= '0;
      quo_q  <= num_i;
      den_q  <= den_i;
    end else if (busy_q) begin
      if (mode_q == rrt_pkg::RD_SQRT) begin
        if (rem_q >= trial) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end else begin
        if (sh >= {1'b0, den_q}) begin
          drem_q <= rrt_pkg::ROOT_W'(sh - {1'b0, den_q});
          quo_q  <= {quo_q[rrt_pkg::NUM_W-2:0], 1'b1};
        end else begin
          drem_q <= sh[rrt_pkg::ROOT_W-1:0];
          quo_q  <= {quo_q[rrt_pkg::NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (mode_q == rrt_pkg::RD_SQRT) ?
                  rrt_pkg::NUM_W'(root_q[rrt_pkg::ROOT_W-1:0]) : quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rrt_tree_extend_step.sv
// Top level of the RRT extend step: sequencer, node and obstacle tables, result register.
// Depends on rrt_pkg, rrt_in_if, rrt_out_if, rrt_ram, rrt_sqdist and rrt_rootdiv.
//
//  channel   direction  transfer when          carries
//  in_i      sink       valid & ready          operation, sample, obstacle entry
//  out_o     source     valid & ready          status, node index, node x/y, parent
//  cfg_*     write      cfg_we_i high          register index and write data
//
// Restart, load and refused operations go straight to the result. An extend scans the
// stored nodes, one node a cycle through the squared distance unit, then takes a square
// root and two divides in the shared root and divide unit (skipped when the target lies
// on the nearest node), then tests one obstacle a cycle and then the goal.
// Reset clears the tree count and goal flag; no clearing pass runs. A waiting result
// does not block the next transfer in; a new result waits in ST_RESP until the last has gone.
`default_nettype none

module rrt_tree_extend_step #(
  parameter int MAX_NODES     = 512,
  parameter int MAX_OBSTACLES = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  rrt_in_if.sink                                  in_i,
  rrt_out_if.source                               out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [rrt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [rrt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int AW    = $clog2(MAX_NODES);
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int OW    = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int OCW   = $clog2(MAX_OBSTACLES + 2);
  localparam int CTR_W = (CW > OCW) ? CW : OCW;
  localparam int CRD   = rrt_pkg::COORD_W;
  localparam int TW    = AW + 2 * CRD;
  localparam int OBW   = rrt_pkg::LEN_W + 2 * CRD;

  // Configuration registers.
  logic signed [CRD-1:0]            start_x_q, start_y_q, goal_x_q, goal_y_q;
  logic [rrt_pkg::LEN_W-1:0]        step_len_q;
  logic [rrt_pkg::OCNT_W-1:0]       obs_count_q;

  // Sequencer and control state.
  rrt_pkg::seq_state_e              state_q, state_d;
  logic [CW-1:0]                    tree_count_q;
  logic                             goal_done_q;
  logic [CTR_W-1:0]                 iss_q, res_q, active;
  logic                             rd_v_q, rd_goal_q;
  logic                             hit_q, goal_hit_q;
  logic                             out_valid_q;

  // Datapath registers.
  logic signed [CRD-1:0]            tx_q, ty_q, cx_q, cy_q;
  logic [rrt_pkg::DIST_W-1:0]       best_q;
  logic signed [rrt_pkg::DIFF_W-1:0] best_dx_q, best_dy_q, ox_q, oy_q;
  logic [AW-1:0]                    near_q;
  logic [rrt_pkg::ROOT_W-1:0]       root_q;
  logic [rrt_pkg::NUM_W-1:0]        num_q;
  logic [2:0]                       rsp_status_q, out_status_q;
  logic [AW-1:0]                    rsp_idx_q, rsp_par_q, out_idx_q, out_par_q;
  logic signed [CRD-1:0]            rsp_x_q, rsp_y_q, out_x_q, out_y_q;

  // Sequencer outputs.
  logic                             in_ready, accept, refuse, coinc, out_free;
  logic                             tree_we, tree_re, obs_we, obs_re, issue_goal;
  logic [AW-1:0]                    tree_waddr;
  logic [TW-1:0]                    tree_wdata, tree_rdata;
  logic [OBW-1:0]                   obs_rdata;
  logic                             rd_start, rd_done;
  rrt_pkg::rd_mode_e                rd_mode;
  logic [rrt_pkg::NUM_W-1:0]        rd_res;

  // Squared distance unit operands.
  logic signed [CRD-1:0]            u_ax, u_ay, u_bx, u_by;
  logic [rrt_pkg::LEN_W-1:0]        u_lim;
  rrt_pkg::sqd_res_t                u_res;

  // Step arithmetic.
  logic signed [rrt_pkg::DIFF_W-1:0] dsel, dabs, nx17, ny17;
  logic [2*CRD-2:0]                 prod;
  logic [CRD-1:0]                   q16;
  logic signed [rrt_pkg::DIFF_W-1:0] qs;
  logic signed [CRD+1:0]            sum_x, sum_y;

  assign accept   = in_i.valid && in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign refuse   = (tree_count_q == '0) || goal_done_q ||
                    (32'(tree_count_q) >= 32'(MAX_NODES));
  assign coinc    = (best_dx_q == '0) && (best_dy_q == '0);

  // Number of obstacle entries that take part in the collision test.
  always_comb begin
    if (32'(obs_count_q) < 32'(MAX_OBSTACLES)) begin
      active = CTR_W'(obs_count_q);
    end else begin
      active = CTR_W'(MAX_OBSTACLES);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrt_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_i.operation == rrt_pkg::OP_EXTEND && !refuse) begin
            state_d = rrt_pkg::ST_SCAN;
          end else begin
            state_d = rrt_pkg::ST_RESP;
          end
        end
      end
      rrt_pkg::ST_SCAN: begin
        if (res_q == CTR_W'(tree_count_q)) begin
          state_d = rrt_pkg::ST_ROOT;
        end
      end
      rrt_pkg::ST_ROOT:   state_d = coinc ? rrt_pkg::ST_SAT : rrt_pkg::ST_ROOT_W;
      rrt_pkg::ST_ROOT_W: if (rd_done) state_d = rrt_pkg::ST_MULX;
      rrt_pkg::ST_MULX:   state_d = rrt_pkg::ST_DIVX;
      rrt_pkg::ST_DIVX:   state_d = rrt_pkg::ST_DIVX_W;
      rrt_pkg::ST_DIVX_W: if (rd_done) state_d = rrt_pkg::ST_MULY;
      rrt_pkg::ST_MULY:   state_d = rrt_pkg::ST_DIVY;
      rrt_pkg::ST_DIVY:   state_d = rrt_pkg::ST_DIVY_W;
      rrt_pkg::ST_DIVY_W: if (rd_done) state_d = rrt_pkg::ST_SAT;
      rrt_pkg::ST_SAT:    state_d = rrt_pkg::ST_OBST;
      rrt_pkg::ST_OBST: begin
        if (res_q == active + 1'b1) begin
          state_d = rrt_pkg::ST_COMMIT;
        end
      end
      rrt_pkg::ST_COMMIT: state_d = rrt_pkg::ST_RESP;
      rrt_pkg::ST_RESP:   if (out_free) state_d = rrt_pkg::ST_IDLE;
      default:            state_d = rrt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    tree_we    = 1'b0;
    tree_waddr = '0;
    tree_wdata = {{AW{1'b0}}, start_x_q, start_y_q};
    tree_re    = 1'b0;
    obs_we     = 1'b0;
    obs_re     = 1'b0;
    issue_goal = 1'b0;
    rd_start   = 1'b0;
    rd_mode    = rrt_pkg::RD_SQRT;
    unique case (state_q)
      rrt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && in_i.operation == rrt_pkg::OP_RESTART) begin
          tree_we = 1'b1;
        end
        if (accept && in_i.operation == rrt_pkg::OP_LOAD &&
            32'(in_i.obstacle_slot) < 32'(MAX_OBSTACLES)) begin
          obs_we = 1'b1;
        end
      end
      rrt_pkg::ST_SCAN: tree_re = iss_q < CTR_W'(tree_count_q);
      rrt_pkg::ST_ROOT: rd_start = !coinc;
      rrt_pkg::ST_DIVX, rrt_pkg::ST_DIVY: begin
        rd_start = 1'b1;
        rd_mode  = rrt_pkg::RD_DIV;
      end
      rrt_pkg::ST_OBST: begin
        obs_re     = iss_q < active;
        issue_goal = iss_q == active;
      end
      rrt_pkg::ST_COMMIT: begin
        if (!hit_q) begin
          tree_we    = 1'b1;
          tree_waddr = tree_count_q[AW-1:0];
          tree_wdata = {near_q, cx_q, cy_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready = in_ready;

  // Node table: parent, x, y in one word.
  rrt_ram #(.WIDTH(TW), .DEPTH(MAX_NODES)) u_tree (
    .clk_i   (clk_i),
    .we_i    (tree_we),
    .waddr_i (tree_waddr),
    .wdata_i (tree_wdata),
    .re_i    (tree_re),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (tree_rdata)
  );

  // Obstacle table: radius, centre x, centre y in one word.
  rrt_ram #(.WIDTH(OBW), .DEPTH(MAX_OBSTACLES)) u_obs (
    .clk_i   (clk_i),
    .we_i    (obs_we),
    .waddr_i (OW'(in_i.obstacle_slot)),
    .wdata_i ({in_i.obstacle_radius, in_i.obstacle_x, in_i.obstacle_y}),
    .re_i    (obs_re),
    .raddr_i (iss_q[OW-1:0]),
    .rdata_o (obs_rdata)
  );

  // Operand selection for the squared distance unit.
  always_comb begin
    if (state_q == rrt_pkg::ST_SCAN) begin
      u_ax  = tx_q;
      u_ay  = ty_q;
      u_bx  = tree_rdata[2*CRD-1:CRD];
      u_by  = tree_rdata[CRD-1:0];
      u_lim = '0;
    end else if (rd_goal_q) begin
      u_ax  = cx_q;
      u_ay  = cy_q;
      u_bx  = goal_x_q;
      u_by  = goal_y_q;
      u_lim = step_len_q;
    end else begin
      u_ax  = cx_q;
      u_ay  = cy_q;
      u_bx  = obs_rdata[2*CRD-1:CRD];
      u_by  = obs_rdata[CRD-1:0];
      u_lim = obs_rdata[OBW-1:2*CRD];
    end
  end

  rrt_sqdist u_sqd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_v_q),
    .ax_i    (u_ax),
    .ay_i    (u_ay),
    .bx_i    (u_bx),
    .by_i    (u_by),
    .lim_i   (u_lim),
    .res_o   (u_res)
  );

  rrt_rootdiv u_rd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rd_start),
    .mode_i  (rd_mode),
    .rad_i   (best_q),
    .num_i   (num_q),
    .den_i   (root_q),
    .done_o  (rd_done),
    .res_o   (rd_res)
  );

  // Rounding numerator |d| * step + m/2, and the signed quotient.
  assign dsel  = (state_q == rrt_pkg::ST_MULX) ? best_dx_q : best_dy_q;
  assign dabs  = dsel[rrt_pkg::DIFF_W-1] ? -dsel : dsel;
  assign prod  = dabs[CRD-1:0] * step_len_q;
  assign q16   = rd_res[CRD-1:0];
  assign qs    = $signed({1'b0, q16});

  // Nearest node position and the saturated candidate.
  assign nx17  = {tx_q[CRD-1], tx_q} - best_dx_q;
  assign ny17  = {ty_q[CRD-1], ty_q} - best_dy_q;
  assign sum_x = {{2{nx17[CRD-1]}}, nx17[CRD-1:0]} + {ox_q[rrt_pkg::DIFF_W-1], ox_q};
  assign sum_y = {{2{ny17[CRD-1]}}, ny17[CRD-1:0]} + {oy_q[rrt_pkg::DIFF_W-1], oy_q};

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rrt_pkg::ST_IDLE;
      start_x_q    <= '0;
      start_y_q    <= '0;
      goal_x_q     <= rrt_pkg::GOAL_X_RST;
      goal_y_q     <= rrt_pkg::GOAL_Y_RST;
      step_len_q   <= rrt_pkg::STEP_LEN_RST;
      obs_count_q  <= '0;
      tree_count_q <= '0;
      goal_done_q  <= 1'b0;
      iss_q        <= '0;
      res_q        <= '0;
      rd_v_q       <= 1'b0;
      rd_goal_q    <= 1'b0;
      hit_q        <= 1'b0;
      goal_hit_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_v_q    <= tree_re || obs_re || issue_goal;
      rd_goal_q <= issue_goal;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rrt_pkg::CFG_START_X:   start_x_q   <= cfg_data_i;
          rrt_pkg::CFG_START_Y:   start_y_q   <= cfg_data_i;
          rrt_pkg::CFG_GOAL_X:    goal_x_q    <= cfg_data_i;
          rrt_pkg::CFG_GOAL_Y:    goal_y_q    <= cfg_data_i;
          rrt_pkg::CFG_STEP_LEN:  step_len_q  <= cfg_data_i[rrt_pkg::LEN_W-1:0];
          rrt_pkg::CFG_OBS_COUNT: obs_count_q <= cfg_data_i[rrt_pkg::OCNT_W-1:0];
          default: begin
          end
        endcase
      end

      case (state_q)
        rrt_pkg::ST_IDLE: begin
          iss_q <= '0;
          res_q <= '0;
          if (accept && in_i.operation == rrt_pkg::OP_RESTART) begin
            tree_count_q <= CW'(1);
            goal_done_q  <= 1'b0;
          end
        end
        rrt_pkg::ST_SCAN: begin
          if (tree_re) iss_q <= iss_q + 1'b1;
          if (u_res.valid) res_q <= res_q + 1'b1;
        end
        rrt_pkg::ST_SAT: begin
          iss_q      <= '0;
          res_q      <= '0;
          hit_q      <= 1'b0;
          goal_hit_q <= 1'b0;
        end
        rrt_pkg::ST_OBST: begin
          if (obs_re || issue_goal) iss_q <= iss_q + 1'b1;
          if (u_res.valid) begin
            res_q <= res_q + 1'b1;
            if (res_q == active) begin
              goal_hit_q <= u_res.le;
            end else if (u_res.le) begin
              hit_q <= 1'b1;
            end
          end
        end
        rrt_pkg::ST_COMMIT: begin
          if (!hit_q) begin
            tree_count_q <= tree_count_q + 1'b1;
            if (goal_hit_q) goal_done_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Result register: loaded once the previous result has gone.
      if (state_q == rrt_pkg::ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      rrt_pkg::ST_IDLE: begin
        tx_q <= in_i.use_goal ? goal_x_q : in_i.sample_x;
        ty_q <= in_i.use_goal ? goal_y_q : in_i.sample_y;
        rsp_idx_q <= '0;
        rsp_par_q <= '0;
        rsp_x_q   <= '0;
        rsp_y_q   <= '0;
        if (in_i.operation == rrt_pkg::OP_RESTART) begin
          rsp_status_q <= rrt_pkg::STATUS_ACK;
          rsp_x_q      <= start_x_q;
          rsp_y_q      <= start_y_q;
        end else if (in_i.operation == rrt_pkg::OP_LOAD) begin
          rsp_status_q <= rrt_pkg::STATUS_ACK;
        end else begin
          rsp_status_q <= rrt_pkg::STATUS_NONE;
        end
      end
      rrt_pkg::ST_SCAN: begin
        // Strictly smaller keeps the first node on ties.
        if (u_res.valid && (res_q == '0 || u_res.dsq < best_q)) begin
          best_q    <= u_res.dsq;
          best_dx_q <= u_res.dx;
          best_dy_q <= u_res.dy;
          near_q    <= res_q[AW-1:0];
        end
      end
      rrt_pkg::ST_ROOT: begin
        // Target on the nearest node: step along +x.
        ox_q <= $signed({2'b00, step_len_q});
        oy_q <= '0;
      end
      rrt_pkg::ST_ROOT_W: if (rd_done) root_q <= rd_res[rrt_pkg::ROOT_W-1:0];
      rrt_pkg::ST_MULX, rrt_pkg::ST_MULY: begin
        num_q <= rrt_pkg::NUM_W'(prod) + rrt_pkg::NUM_W'(root_q >> 1);
      end
      rrt_pkg::ST_DIVX_W: if (rd_done) ox_q <= best_dx_q[rrt_pkg::DIFF_W-1] ? -qs : qs;
      rrt_pkg::ST_DIVY_W: if (rd_done) oy_q <= best_dy_q[rrt_pkg::DIFF_W-1] ? -qs : qs;
      rrt_pkg::ST_SAT: begin
        cx_q <= rrt_pkg::sat16(sum_x);
        cy_q <= rrt_pkg::sat16(sum_y);
      end
      rrt_pkg::ST_COMMIT: begin
        rsp_x_q   <= cx_q;
        rsp_y_q   <= cy_q;
        rsp_par_q <= near_q;
        if (hit_q) begin
          rsp_status_q <= rrt_pkg::STATUS_REJECT;
          rsp_idx_q    <= '0;
        end else begin
          rsp_status_q <= goal_hit_q ? rrt_pkg::STATUS_GOAL : rrt_pkg::STATUS_ADDED;
          rsp_idx_q    <= tree_count_q[AW-1:0];
        end
      end
      rrt_pkg::ST_RESP: begin
        if (out_free) begin
          out_status_q <= rsp_status_q;
          out_idx_q    <= rsp_idx_q;
          out_par_q    <= rsp_par_q;
          out_x_q      <= rsp_x_q;
          out_y_q      <= rsp_y_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.node_index   = out_idx_q;
  assign out_o.node_x       = out_x_q;
  assign out_o.node_y       = out_y_q;
  assign out_o.parent_index = out_par_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rrt_checker.sv
// Port level checker of the RRT extend step, bound to the top level.
// Depends on rrt_pkg for the status codes.
`default_nettype none

module rrt_checker #(
  parameter int IDX_W = 9
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [2:0]         out_status,
  input wire logic [IDX_W-1:0]   out_node_index,
  input wire logic signed [15:0] out_node_x,
  input wire logic signed [15:0] out_node_y,
  input wire logic [IDX_W-1:0]   out_parent_index
);

  // One item at a time: after an input transfer the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // A stalled result is kept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Only an added node carries a node index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status != rrt_pkg::STATUS_ADDED &&
    out_status != rrt_pkg::STATUS_GOAL |-> out_node_index == '0)
    else $error("node index set on a result that added no node");

  // A refused operation reports all fields zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status == rrt_pkg::STATUS_NONE |->
    out_node_x == '0 && out_node_y == '0 && out_parent_index == '0)
    else $error("refused operation with non-zero fields");

endmodule

bind rrt_tree_extend_step rrt_checker #(.IDX_W($clog2(MAX_NODES))) u_rrt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid         (in_i.valid),
  .in_ready         (in_i.ready),
  .out_valid        (out_o.valid),
  .out_ready        (out_o.ready),
  .out_status       (out_o.status),
  .out_node_index   (out_o.node_index),
  .out_node_x       (out_o.node_x),
  .out_node_y       (out_o.node_y),
  .out_parent_index (out_o.parent_index)
);

`default_nettype wire
